>>> rtl/indexed_doubly_linked_list_defines.svh
// Assertion macros used by the list RTL.
// No dependencies; included by indexed_doubly_linked_list.sv, which carries the checks.
`ifndef INDEXED_DOUBLY_LINKED_LIST_DEFINES_SVH
`define INDEXED_DOUBLY_LINKED_LIST_DEFINES_SVH

// prop must hold at every clock edge outside reset
`define IDLL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("list assertion failed");

// cond must never be seen at a clock edge outside reset
`define IDLL_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("list forbidden condition seen");

`endif

>>> rtl/idll_pkg.sv
// Package for the indexed doubly linked list: field widths, defaults,
// operation and status codes, sequencer states. No dependencies.
package idll_pkg;

  localparam int CapacityDef  = 1024;
  localparam int DataWidthDef = 32;

  localparam int OpW   = 3;
  localparam int SlotW = 10;
  localparam int ValW  = 32;
  localparam int StatW = 2;
  localparam int CntW  = 11;

  typedef enum logic [OpW-1:0] {
    OP_FRONT  = 3'd0,
    OP_BACK   = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5,
    OP_SEARCH = 3'd6,
    OP_RANGE  = 3'd7
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_USED  = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_LINK,
    ST_SCAN,
    ST_DROP,
    ST_DONE
  } state_e;

endpackage

>>> rtl/idll_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
module idll_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/indexed_doubly_linked_list.sv
// Sequence from accept to result: add passes the check, link and result states; remove
// passes check, drop and result; read and write pass check and result; search scans the
// list from the head until a hit or its end; range removal drops up to the end slot.
// Flow: one request at a time under the sequencer; the next word is taken in the idle
// state after the result leaves, so a request cannot start before the last is through.
// Reset: asynchronous, active low. A clearing pass zeroes the in-use RAM one slot per
// cycle; no request is taken until it ends.
module indexed_doubly_linked_list
  import idll_pkg::*;
#(
  parameter int CAPACITY   = CapacityDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OpW-1:0]          operation_i,
  input  logic [SlotW-1:0]        slot_i,
  input  logic [SlotW-1:0]        end_slot_i,
  input  logic signed [ValW-1:0]  value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [StatW-1:0]        status_o,
  output logic signed [ValW-1:0]  data_out_o,
  output logic [SlotW-1:0]        result_slot_o,
  output logic                    result_slot_valid_o,
  output logic [CntW-1:0]         element_count_o,
  output logic [CntW-1:0]         removed_count_o
);

`include "indexed_doubly_linked_list_defines.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [SlotW-1:0] s_q, s_d, e_q, e_d;
  logic [DATA_WIDTH-1:0] v_q, v_d;
  logic [LW-1:0] cur_q, cur_d, p_q, p_d, n_q, n_d;
  logic first_q, first_d;
  logic [LW-1:0] head_q, head_d, tail_q, tail_d, count_q, count_d;
  logic [LW-1:0] free_top_q, free_top_d, hw_q, hw_d;
  status_e status_q, status_d;
  logic [ValW-1:0] data_q, data_d;
  logic [LW-1:0] rslot_q, rslot_d, removed_q, removed_d;
  logic rvalid_q, rvalid_d;
  logic [AW-1:0] clr_q, clr_d;

  // RAM ports
  logic [AW-1:0] addr, used_raddr, fstk_raddr;
  logic [DATA_WIDTH-1:0] elem_rd, elem_wd;
  logic [LW-1:0] nxt_rd, prv_rd, nxt_wd, prv_wd;
  logic used_rd, used_wd;
  logic [AW-1:0] fstk_rd, fstk_wd;
  logic elem_we, nxt_we, prv_we, used_we, fstk_we;
  logic [AW-1:0] elem_wa, nxt_wa, prv_wa, used_wa, fstk_wa;

  logic [ValW-1:0] elem_sx;
  logic s_ok, e_ok, in_acc;
  logic [LW-1:0] nw, pp, nn;
  logic alloc_ok;

  assign elem_sx = ValW'(signed'(elem_rd));
  assign s_ok    = (s_q < CAPACITY) && used_rd;
  assign e_ok    = (e_q < CAPACITY) && used_rd;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign fstk_raddr = AW'(free_top_q - LW'(1));

  idll_ram #(.Width(DATA_WIDTH), .Depth(CAPACITY)) u_elem (
    .clk_i, .we_i(elem_we), .waddr_i(elem_wa), .wdata_i(elem_wd),
    .raddr_i(addr), .rdata_o(elem_rd));
  idll_ram #(.Width(LW), .Depth(CAPACITY)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .raddr_i(addr), .rdata_o(nxt_rd));
  idll_ram #(.Width(LW), .Depth(CAPACITY)) u_prev (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .raddr_i(addr), .rdata_o(prv_rd));
  idll_ram #(.Width(1), .Depth(CAPACITY)) u_used (
    .clk_i, .we_i(used_we), .waddr_i(used_wa), .wdata_i(used_wd),
    .raddr_i(used_raddr), .rdata_o(used_rd));
  idll_ram #(.Width(AW), .Depth(CAPACITY)) u_free (
    .clk_i, .we_i(fstk_we), .waddr_i(fstk_wa), .wdata_i(fstk_wd),
    .raddr_i(fstk_raddr), .rdata_o(fstk_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      head_q     <= NIL;
      tail_q     <= NIL;
      count_q    <= '0;
      free_top_q <= '0;
      hw_q       <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      free_top_q <= free_top_d;
      hw_q       <= hw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    s_q       <= s_d;
    e_q       <= e_d;
    v_q       <= v_d;
    cur_q     <= cur_d;
    p_q       <= p_d;
    n_q       <= n_d;
    first_q   <= first_d;
    status_q  <= status_d;
    data_q    <= data_d;
    rslot_q   <= rslot_d;
    rvalid_q  <= rvalid_d;
    removed_q <= removed_d;
  end

  always_comb begin
    state_d = state_q;   op_d = op_q;       s_d = s_q;   e_d = e_q;  v_d = v_q;
    cur_d = cur_q;       p_d = p_q;         n_d = n_q;   first_d = first_q;
    head_d = head_q;     tail_d = tail_q;   count_d = count_q;
    free_top_d = free_top_q;  hw_d = hw_q;  clr_d = clr_q;
    status_d = status_q; data_d = data_q;   rslot_d = rslot_q;
    rvalid_d = rvalid_q; removed_d = removed_q;
    addr = cur_q[AW-1:0];
    used_raddr = cur_q[AW-1:0];
    elem_we = 1'b0; elem_wa = '0; elem_wd = v_q;
    nxt_we = 1'b0;  nxt_wa = '0;  nxt_wd = NIL;
    prv_we = 1'b0;  prv_wa = '0;  prv_wd = NIL;
    used_we = 1'b0; used_wa = '0; used_wd = 1'b0;
    fstk_we = 1'b0; fstk_wa = free_top_q[AW-1:0]; fstk_wd = cur_q[AW-1:0];
    nw = NIL; pp = NIL; nn = nxt_rd; alloc_ok = 1'b0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        used_we = 1'b1;
        used_wa = clr_q;
        clr_d   = clr_q + AW'(1);
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        addr = (op_e'(operation_i) == OP_SEARCH) ? head_q[AW-1:0] : AW'(slot_i);
        used_raddr = (op_e'(operation_i) == OP_RANGE) ? AW'(end_slot_i) : AW'(slot_i);
        if (in_acc) begin
          op_d = op_e'(operation_i);
          s_d = slot_i;
          e_d = end_slot_i;
          v_d = DATA_WIDTH'(value_i);
          cur_d = (op_e'(operation_i) == OP_SEARCH) ? head_q : LW'(slot_i);
          first_d = 1'b1;
          status_d = STAT_OK;
          data_d = '0;
          rslot_d = '0;
          rvalid_d = 1'b0;
          removed_d = '0;
          state_d = (op_e'(operation_i) == OP_SEARCH) ? ST_SCAN : ST_CHECK;
        end
      end
      ST_CHECK: begin
        case (op_q)
          OP_FRONT, OP_BACK, OP_INSERT: begin
            if (op_q == OP_INSERT && !s_ok) begin
              status_d = STAT_NOT_USED;
              state_d  = ST_DONE;
            end else if (free_top_q != '0) begin
              nw = LW'(fstk_rd);
              free_top_d = free_top_q - LW'(1);
              alloc_ok = 1'b1;
            end else if (hw_q < NIL) begin
              nw = hw_q;
              hw_d = hw_q + LW'(1);
              alloc_ok = 1'b1;
            end else begin
              status_d = STAT_FULL;
              state_d  = ST_DONE;
            end
            if (alloc_ok) begin
              elem_we = 1'b1; elem_wa = nw[AW-1:0];
              used_we = 1'b1; used_wa = nw[AW-1:0]; used_wd = 1'b1;
              nxt_we = 1'b1;  nxt_wa = nw[AW-1:0];
              prv_we = 1'b1;  prv_wa = nw[AW-1:0];
              case (op_q)
                OP_FRONT: begin
                  nxt_wd = head_q;
                  prv_wd = NIL;
                end
                OP_BACK: begin
                  nxt_wd = NIL;
                  prv_wd = tail_q;
                end
                default: begin
                  nxt_wd = nxt_rd;
                  prv_wd = LW'(s_q);
                end
              endcase
              p_d = nxt_rd;
              n_d = nw;
              count_d = count_q + LW'(1);
              rslot_d = nw;
              rvalid_d = 1'b1;
              state_d = ST_LINK;
            end
          end
          OP_READ, OP_WRITE: begin
            if (!s_ok) begin
              status_d = STAT_NOT_USED;
            end else begin
              data_d = elem_sx;
              if (op_q == OP_WRITE) begin
                elem_we = 1'b1;
                elem_wa = cur_q[AW-1:0];
              end
            end
            state_d = ST_DONE;
          end
          OP_REMOVE: begin
            if (!s_ok) begin
              status_d = STAT_NOT_USED;
              state_d  = ST_DONE;
            end else begin
              state_d  = ST_DROP;
            end
          end
          OP_RANGE: begin
            // end slot was looked up first; start slot is checked in the drop
            if (!e_ok) begin
              status_d = STAT_NOT_USED;
              state_d  = ST_DONE;
            end else begin
              state_d  = ST_DROP;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_LINK: begin
        case (op_q)
          OP_FRONT: begin
            if (head_q != NIL) begin
              prv_we = 1'b1; prv_wa = head_q[AW-1:0]; prv_wd = n_q;
            end else begin
              tail_d = n_q;
            end
            head_d = n_q;
          end
          OP_BACK: begin
            if (tail_q != NIL) begin
              nxt_we = 1'b1; nxt_wa = tail_q[AW-1:0]; nxt_wd = n_q;
            end else begin
              head_d = n_q;
            end
            tail_d = n_q;
          end
          default: begin
            nxt_we = 1'b1; nxt_wa = AW'(s_q); nxt_wd = n_q;
            if (p_q != NIL) begin
              prv_we = 1'b1; prv_wa = p_q[AW-1:0]; prv_wd = n_q;
            end else begin
              tail_d = n_q;
            end
          end
        endcase
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (cur_q == NIL) begin
          status_d = STAT_NOT_FOUND;
          state_d  = ST_DONE;
        end else if (elem_rd == v_q) begin
          data_d   = elem_sx;
          rslot_d  = cur_q;
          rvalid_d = 1'b1;
          state_d  = ST_DONE;
        end else begin
          cur_d = nxt_rd;
          addr  = nxt_rd[AW-1:0];
        end
      end
      ST_DROP: begin
        if (first_q && !s_ok) begin
          status_d = STAT_NOT_USED;
          state_d  = ST_DONE;
        end else begin
          // after the first word the predecessor stays the same
          pp = first_q ? prv_rd : p_q;
          if (pp != NIL) begin
            nxt_we = 1'b1; nxt_wa = pp[AW-1:0]; nxt_wd = nn;
          end else begin
            head_d = nn;
          end
          if (nn != NIL) begin
            prv_we = 1'b1; prv_wa = nn[AW-1:0]; prv_wd = pp;
          end else begin
            tail_d = pp;
          end
          used_we = 1'b1; used_wa = cur_q[AW-1:0]; used_wd = 1'b0;
          if (free_top_q < NIL) begin
            fstk_we = 1'b1;
            free_top_d = free_top_q + LW'(1);
          end
          count_d   = count_q - LW'(1);
          removed_d = removed_q + LW'(1);
          data_d    = elem_sx;
          if (op_q == OP_REMOVE || cur_q == LW'(e_q) || nn == NIL) begin
            rslot_d  = (nn != NIL) ? nn : '0;
            rvalid_d = (nn != NIL);
            state_d  = ST_DONE;
          end else begin
            cur_d   = nn;
            p_d     = pp;
            first_d = 1'b0;
            addr    = nn[AW-1:0];
          end
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign status_o            = status_q;
  assign data_out_o          = data_q;
  assign result_slot_o       = SlotW'(rslot_q);
  assign result_slot_valid_o = rvalid_q;
  assign element_count_o     = CntW'(count_q);
  assign removed_count_o     = CntW'(removed_q);

  `IDLL_ASSERT(a_count_max, clk_i, rst_ni, count_q <= NIL)
  `IDLL_ASSERT(a_free_below_hw, clk_i, rst_ni, free_top_q <= hw_q)
  `IDLL_ASSERT(a_empty_head, clk_i, rst_ni,
               state_q != ST_IDLE || ((head_q == NIL) == (count_q == '0)))
  `IDLL_NEVER(a_no_accept_busy, clk_i, rst_ni, out_valid_o && !in_stall_o)

endmodule
